// ===== hw/rtl/fbr_pkg.sv =====
package fbr_pkg;

    // Default screen geometry
    localparam int DEF_SCREEN_COLUMNS = 128;
    localparam int DEF_SCREEN_ROWS    = 64;

    // Pixels per page (vertical byte) and first data phase of a page
    localparam int PAGE_HEIGHT = 8;
    localparam int DATA_PHASE  = 3;

    // Item kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAGE_BASE   = 2'd0;
    localparam logic [1:0] CFG_COLUMN_LOW  = 2'd1;
    localparam logic [1:0] CFG_COLUMN_HIGH = 2'd2;
    localparam logic [1:0] CFG_REVERSE     = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_PAGE_BASE   = 8'd176;
    localparam logic [7:0] RST_COLUMN_LOW  = 8'd0;
    localparam logic [7:0] RST_COLUMN_HIGH = 8'd16;
    localparam logic       RST_REVERSE     = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic pix_rd;     // read byte under pixel, capture pixel fields
        logic pix_wr;     // write back modified byte
        logic ref_rd;     // read byte at refresh position
        logic ref_load;   // load result register, advance refresh position
        logic clr_start;  // restart clear sweep
        logic clr_step;   // zero one entry
    } fbr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pix_ok;     // pixel coordinates on screen
        logic clr_last;   // clear sweep at last entry
        logic out_free;   // result register can take a new item
    } fbr_sts_t;

endpackage

// ===== hw/rtl/fbr_ctrl.sv =====
module fbr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  fbr_pkg::fbr_sts_t sts,
    output fbr_pkg::fbr_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PIX   = 2'd2;
    localparam logic [1:0] ST_REF   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        fbr_pkg::KIND_PIXEL:
                        begin
                            // off-screen pixels are dropped here
                            cmd.pix_rd = sts.pix_ok;
                            if (sts.pix_ok)
                            begin
                                state_next = ST_PIX;
                            end
                        end
                        fbr_pkg::KIND_REFRESH:
                        begin
                            cmd.ref_rd = 1'b1;
                            state_next = ST_REF;
                        end
                        fbr_pkg::KIND_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIX:
            begin
                cmd.pix_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REF:
            begin
                if (sts.out_free)
                begin
                    cmd.ref_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    // State register; reset starts with a clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/fbr_datapath.sv =====
module fbr_datapath
#(
    parameter int SCREEN_COLUMNS = fbr_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = fbr_pkg::DEF_SCREEN_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        x,
    input  logic [7:0]        y,
    input  logic              color,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              is_data,
    output logic              frame_done,
    input  fbr_pkg::fbr_cmd_t cmd,
    output fbr_pkg::fbr_sts_t sts
);

    localparam int PAGE_COUNT = (SCREEN_ROWS + fbr_pkg::PAGE_HEIGHT - 1) / fbr_pkg::PAGE_HEIGHT;
    localparam int STORE_SIZE = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int PH_W       = $clog2(SCREEN_COLUMNS + fbr_pkg::DATA_PHASE);

    localparam logic [PH_W-1:0]   PH_DATA  = PH_W'(fbr_pkg::DATA_PHASE);
    localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(SCREEN_COLUMNS + fbr_pkg::DATA_PHASE - 1);
    localparam logic [PAGE_W-1:0] PG_LAST  = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(STORE_SIZE - 1);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLUMNS);

    // Configuration registers
    logic [7:0] cfg_page_base_reg;
    logic [7:0] cfg_column_low_reg;
    logic [7:0] cfg_column_high_reg;
    logic       cfg_reverse_reg;

    // Refresh position
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   phase_next;
    logic              wrap_page;
    logic              wrap_frame;

    // Pixel write state
    logic [ADDR_W-1:0] pix_addr_reg;
    logic [2:0]        bit_reg;
    logic              color_reg;
    logic [ADDR_W-1:0] pix_addr;

    // Clear sweep
    logic [ADDR_W-1:0] clr_addr_reg;

    // Memory ports
    logic [7:0]        frame_mem [STORE_SIZE];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              wr_en;
    logic [7:0]        pix_mask;
    logic [COL_W-1:0]  ref_col;
    logic [ADDR_W-1:0] ref_addr;

    // Result register
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              is_data_reg;
    logic              frame_done_reg;
    logic [7:0]        res_byte;
    logic [PAGE_W-1:0] disp_page;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_page_base_reg   <= fbr_pkg::RST_PAGE_BASE;
            cfg_column_low_reg  <= fbr_pkg::RST_COLUMN_LOW;
            cfg_column_high_reg <= fbr_pkg::RST_COLUMN_HIGH;
            cfg_reverse_reg     <= fbr_pkg::RST_REVERSE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbr_pkg::CFG_PAGE_BASE:   cfg_page_base_reg   <= cfg_data;
                fbr_pkg::CFG_COLUMN_LOW:  cfg_column_low_reg  <= cfg_data;
                fbr_pkg::CFG_COLUMN_HIGH: cfg_column_high_reg <= cfg_data;
                fbr_pkg::CFG_REVERSE:     cfg_reverse_reg     <= cfg_data[0];
            endcase
        end
    end

    // Pixel address and range check
    assign pix_addr = ADDR_W'(y[7:3]) * COLS_A + ADDR_W'(x);
    assign sts.pix_ok = ({1'b0, x} < 9'(SCREEN_COLUMNS)) && ({1'b0, y} < 9'(SCREEN_ROWS));

    always_ff @(posedge clk)
    begin
        if (cmd.pix_rd)
        begin
            pix_addr_reg <= pix_addr;
            bit_reg      <= y[2:0];
            color_reg    <= color;
        end
    end

    // Refresh read address; command phases read column 0
    assign ref_col  = (phase_reg >= PH_DATA) ? COL_W'(phase_reg - PH_DATA) : '0;
    assign ref_addr = ADDR_W'(page_reg) * COLS_A + ADDR_W'(ref_col);

    // Memory port selection
    assign pix_mask = 8'h80 >> bit_reg;
    assign rd_en    = cmd.pix_rd || cmd.ref_rd;
    assign rd_addr  = cmd.pix_rd ? pix_addr : ref_addr;
    assign wr_en    = cmd.clr_step || cmd.pix_wr;
    assign wr_addr  = cmd.clr_step ? clr_addr_reg : pix_addr_reg;
    assign wr_data  = cmd.clr_step ? 8'h00
                    : (color_reg ? (rd_data_reg | pix_mask) : (rd_data_reg & ~pix_mask));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Clear sweep address
    assign sts.clr_last = (clr_addr_reg == ADDR_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= sts.clr_last ? '0 : ADDR_W'(clr_addr_reg + 1'b1);
        end
    end

    // Refresh position advance
    assign wrap_page  = (phase_reg == PH_LAST);
    assign wrap_frame = wrap_page && (page_reg == PG_LAST);
    assign phase_next = wrap_page ? '0 : PH_W'(phase_reg + 1'b1);
    assign page_next  = wrap_frame ? '0 : (wrap_page ? PAGE_W'(page_reg + 1'b1) : page_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            phase_reg <= '0;
        end
        else if (cmd.ref_load)
        begin
            page_reg  <= page_next;
            phase_reg <= phase_next;
        end
    end

    // Result byte for the current phase
    assign disp_page = cfg_reverse_reg ? PAGE_W'(PG_LAST - page_reg) : page_reg;

    always_comb
    begin
        priority if (phase_reg == '0)
        begin
            res_byte = cfg_page_base_reg | 8'(disp_page);
        end
        else if (phase_reg == PH_W'(1))
        begin
            res_byte = cfg_column_low_reg;
        end
        else if (phase_reg == PH_W'(2))
        begin
            res_byte = cfg_column_high_reg;
        end
        else
        begin
            res_byte = rd_data_reg;
        end
    end

    // Result register
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ref_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ref_load)
        begin
            out_byte_reg   <= res_byte;
            is_data_reg    <= (phase_reg >= PH_DATA);
            frame_done_reg <= wrap_frame;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_data    = is_data_reg;
    assign frame_done = frame_done_reg;

    // Refresh position stays inside the frame
    a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg <= PG_LAST)
        else $error("refresh page out of range");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_LAST)
        else $error("refresh phase out of range");

    // Frame end is flagged only on a data byte
    a_done_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> is_data)
        else $error("frame end on command byte");

    // A result is never loaded over one that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ref_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // A frame end leaves the position at the first page command
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ref_load && wrap_frame |=> (page_reg == '0) && (phase_reg == '0))
        else $error("frame wrap failed");

endmodule

// ===== hw/rtl/page_framebuffer_refresher.sv =====
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | kind, x, y, color
// out     | out_valid / out_ready | out_byte, is_data, frame_done
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Pixel write: read then write of the one-port-per-direction store.
// Refresh step: store read, then load of the result register, held while it stays full.
// Clear: SCREEN_COLUMNS * pages store entries, one store entry zeroed per cycle.
// After reset the same clearing pass runs with in_ready low; cfg writes are
// taken at any time.
// A waiting result does not block pixel writes or clears.
module page_framebuffer_refresher
#(
    parameter int SCREEN_COLUMNS = fbr_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = fbr_pkg::DEF_SCREEN_ROWS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic       color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       frame_done,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    fbr_pkg::fbr_cmd_t cmd;
    fbr_pkg::fbr_sts_t sts;

    fbr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbr_datapath
    #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .x          (x),
        .y          (y),
        .color      (color),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .frame_done (frame_done),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
